FILE: src/scla_pkg.sv
`default_nettype none
package scla_pkg;

   // input item
   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   // result item
   typedef struct packed {
      logic       out_kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   // source of the bytes sent during a burst
   typedef enum logic [1:0] {
      SRC_PROMPT,
      SRC_ERASE,
      SRC_LINE,
      SRC_ECHO
   } src_type;

   // input kinds
   localparam logic KIND_BYTE     = 1'b0;
   localparam logic KIND_CONSUMED = 1'b1;

   // result kinds
   localparam logic OUT_TX  = 1'b0;
   localparam logic OUT_CMD = 1'b1;

   // character codes
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_LO = 8'h20;
   localparam logic [7:0] CH_HI = 8'h7E;

   localparam int PROMPT_LEN = 10;
   localparam int ERASE_LEN  = 9;

   // prompt string: cr, lf and eight text bytes
   function automatic logic [7:0] prompt_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h0D;
         4'd1:    b = 8'h0A;
         4'd2:    b = 8'h31;
         4'd3:    b = 8'h39;
         4'd4:    b = 8'h31;
         4'd5:    b = 8'h30;
         4'd6:    b = 8'h41;
         4'd7:    b = 8'h20;
         4'd8:    b = 8'h3E;
         4'd9:    b = 8'h20;
         default: b = 8'h20;
      endcase
      return b;
   endfunction

   // cursor back, blank, cursor back
   function automatic logic [7:0] erase_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h1B;
         4'd1:    b = 8'h5B;
         4'd2:    b = 8'h31;
         4'd3:    b = 8'h44;
         4'd4:    b = 8'h20;
         4'd5:    b = 8'h1B;
         4'd6:    b = 8'h5B;
         4'd7:    b = 8'h31;
         4'd8:    b = 8'h44;
         default: b = 8'h20;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: src/scla_line_ram.sv
`default_nettype none
module scla_line_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, out of range addresses never used for data
   always_ff @(posedge clock) begin
      if (32'(rd_addr) < DEPTH) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/serial_command_line_assembler_unit.sv
`default_nettype none
// channel   direction  payload   handshake
// req       in         req_type  req_valid / req_stall
// rsp       out        rsp_type  rsp_valid / rsp_stall
//
// One item per transfer at req; the block then stalls req while it sends the
// results, one per cycle unless rsp stalls, from a shared index counter and
// end compare. Echo sends one byte, erase 9, prompt 10, a command line one per
// stored byte; dropped bytes send nothing and leave req unstalled.
// Reset clears the sequencer, the line length and the output valid; the line
// store holds no reset. A stall at rsp holds the output register and the burst.
module serial_command_line_assembler_unit
   import scla_pkg::*;
#(
   parameter int LINE_MAX = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   localparam int LEN_W  = $clog2(LINE_MAX + 1);
   localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam int CNT_W  = (LEN_W > 4) ? LEN_W : 4;

   state_type          state_ff, state_in;
   src_type            src_ff, src_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   end_ff, end_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [7:0]         echo_ff, echo_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               slot_free;
   logic [CNT_W-1:0]   idx_next;
   logic               is_last;
   logic [7:0]         send_byte;
   logic               wr_en;
   logic [7:0]         rd_data;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // shared index step and end compare
   assign idx_next = idx_ff + CNT_W'(1);
   assign is_last  = (idx_next == end_ff);

   // byte for the current position of the burst
   always_comb begin
      case (src_ff)
         SRC_PROMPT: send_byte = prompt_byte(idx_ff[3:0]);
         SRC_ERASE:  send_byte = erase_byte(idx_ff[3:0]);
         SRC_LINE:   send_byte = rd_data;
         SRC_ECHO:   send_byte = echo_ff;
         default:    send_byte = echo_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      len_in       = len_ff;
      echo_in      = echo_ff;
      wr_en        = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in  = '0;
               echo_in = req_data.rx_byte;
               if (req_data.kind == KIND_CONSUMED) begin
                  src_in   = SRC_PROMPT;
                  end_in   = CNT_W'(PROMPT_LEN);
                  state_in = ST_SEND;
               end else if (req_data.rx_byte == CH_CR) begin
                  if (len_ff == '0) begin
                     src_in = SRC_PROMPT;
                     end_in = CNT_W'(PROMPT_LEN);
                  end else begin
                     src_in = SRC_LINE;
                     end_in = CNT_W'(len_ff);
                     len_in = '0;
                  end
                  state_in = ST_SEND;
               end else if (req_data.rx_byte inside {[CH_LO:CH_HI]}) begin
                  if (len_ff < LEN_W'(LINE_MAX)) begin
                     wr_en    = 1'b1;
                     len_in   = len_ff + LEN_W'(1);
                     src_in   = SRC_ECHO;
                     end_in   = CNT_W'(1);
                     state_in = ST_SEND;
                  end
               end else if (req_data.rx_byte == CH_BS) begin
                  if (len_ff != '0) begin
                     len_in   = len_ff - LEN_W'(1);
                     src_in   = SRC_ERASE;
                     end_in   = CNT_W'(ERASE_LEN);
                     state_in = ST_SEND;
                  end
               end
            end
         end
         ST_SEND: begin
            if (slot_free) begin
               rsp_in.out_kind = (src_ff == SRC_LINE) ? OUT_CMD : OUT_TX;
               rsp_in.out_byte = send_byte;
               rsp_in.last     = is_last;
               rsp_valid_in    = 1'b1;
               idx_in          = idx_next;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // burst and payload registers
   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      idx_ff  <= idx_in;
      end_ff  <= end_in;
      echo_ff <= echo_in;
      rsp_ff  <= rsp_in;
   end

   // line store, read one step ahead so data lines up with idx_ff
   scla_line_ram #(
      .DEPTH  (LINE_MAX),
      .ADDR_W (ADDR_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req_data.rx_byte),
      .rd_addr (idx_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb
   import scla_pkg::*;
();

   localparam int LINE_MAX = 32;

   // fixed byte strings sent by the block
   localparam logic [7:0] PROMPT_TEXT [10] = '{
      8'h0D, 8'h0A, 8'h31, 8'h39, 8'h31, 8'h30, 8'h41, 8'h20, 8'h3E, 8'h20
   };
   localparam logic [7:0] ERASE_TEXT [9] = '{
      8'h1B, 8'h5B, 8'h31, 8'h44, 8'h20, 8'h1B, 8'h5B, 8'h31, 8'h44
   };

   // tracks the edit line and the bytes the block should send
   class line_echo_scoreboard;
      rsp_type    awaited_q[$];
      logic [7:0] line_buf [LINE_MAX];
      int         line_len;
      int         errors;

      function new();
         line_len = 0;
         errors   = 0;
      endfunction

      function void await_byte(input logic out_kind, input logic [7:0] ch);
         rsp_type e;
         e.out_kind = out_kind;
         e.out_byte = ch;
         e.last     = 1'b0;
         awaited_q.push_back(e);
      endfunction

      // works out the results of one accepted input transfer
      function int note_received(input req_type item);
         int start_size;
         int i;
         start_size = awaited_q.size();
         if (item.kind == KIND_CONSUMED) begin
            for (i = 0; i < 10; i++) await_byte(OUT_TX, PROMPT_TEXT[i]);
         end else if (item.rx_byte == CH_CR) begin
            if (line_len == 0) begin
               for (i = 0; i < 10; i++) await_byte(OUT_TX, PROMPT_TEXT[i]);
            end else begin
               for (i = 0; i < line_len; i++) await_byte(OUT_CMD, line_buf[i]);
               line_len = 0;
            end
         end else if (item.rx_byte >= CH_LO && item.rx_byte <= CH_HI) begin
            // full line drops the byte with no echo
            if (line_len < LINE_MAX) begin
               line_buf[line_len] = item.rx_byte;
               line_len++;
               await_byte(OUT_TX, item.rx_byte);
            end
         end else if (item.rx_byte == CH_BS && line_len != 0) begin
            line_len--;
            for (i = 0; i < 9; i++) await_byte(OUT_TX, ERASE_TEXT[i]);
         end
         if (awaited_q.size() > start_size) awaited_q[awaited_q.size() - 1].last = 1'b1;
         return awaited_q.size() - start_size;
      endfunction

      function void report(input string field, input logic [7:0] want, input logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
         end
      endfunction

      // compares one result transfer with the oldest expectation
      function void check_output(input rsp_type got);
         rsp_type want;
         if (awaited_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %b/%02h/%b",
                     $time, got.out_kind, got.out_byte, got.last);
         end else begin
            want = awaited_q.pop_front();
            report("out_kind", {7'd0, want.out_kind}, {7'd0, got.out_kind});
            report("out_byte", want.out_byte, got.out_byte);
            report("last", {7'd0, want.last}, {7'd0, got.last});
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   line_echo_scoreboard sb = new();
   int accepted_items = 0;

   serial_command_line_assembler_unit #(
      .LINE_MAX (LINE_MAX)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // offer one item, at times after a random gap, and wait for its transfer
   task automatic send_item(input logic kind, input logic [7:0] ch);
      req_type item;
      item.kind    = kind;
      item.rx_byte = ch;
      if (accepted_items < 400 && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(sb.note_received(item));
      accepted_items++;
   endtask

   // one edited line with random content, mostly closed by a carriage return
   task automatic send_line(input bit clean);
      int n;
      int i;
      int r;
      if (clean) n = 40;
      else if ($urandom_range(0, 11) == 0) n = $urandom_range(28, 40);
      else n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) begin
         r = clean ? 99 : $urandom_range(0, 99);
         if (r < 10) send_item(KIND_BYTE, CH_BS);
         else if (r < 15) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
         else if (r < 18) send_item(KIND_CONSUMED, 8'($urandom_range(0, 255)));
         else send_item(KIND_BYTE, 8'($urandom_range(CH_LO, CH_HI)));
      end
      r = $urandom_range(0, 19);
      if (r < 17) send_item(KIND_BYTE, CH_CR);
      else if (r < 19) send_item(KIND_CONSUMED, 8'($urandom_range(0, 255)));
   endtask

   // result side stalls in bursts, with one long hold to back up the input
   initial begin
      bit held;
      bit stall_on;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && accepted_items >= 60) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else if (accepted_items >= 400) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            stall_on = ($urandom_range(0, 2) == 0);
            rsp_stall <= stall_on;
            repeat (stall_on ? $urandom_range(1, 10) : $urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_output(rsp_data);
   end

   // stimulus and end of run
   initial begin
      int waited;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: prompt paths, dropped bytes, range edges, erase and command
      send_item(KIND_CONSUMED, 8'hFF);
      send_item(KIND_BYTE, CH_CR);
      send_item(KIND_BYTE, CH_BS);
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'h1F);
      send_item(KIND_BYTE, 8'h7F);
      send_item(KIND_BYTE, 8'h80);
      send_item(KIND_BYTE, 8'hFF);
      send_item(KIND_BYTE, 8'h0A);
      send_item(KIND_BYTE, CH_LO);
      send_item(KIND_BYTE, CH_HI);
      send_item(KIND_BYTE, 8'h41);
      send_item(KIND_BYTE, CH_BS);
      send_item(KIND_CONSUMED, CH_CR);
      send_item(KIND_BYTE, CH_CR);
      send_item(KIND_BYTE, CH_CR);
      send_item(KIND_CONSUMED, CH_BS);
      send_item(KIND_CONSUMED, 8'h41);
      send_item(KIND_BYTE, 8'h78);
      send_item(KIND_BYTE, CH_CR);

      // random lines, the first one long enough to fill the line
      send_line(1'b1);
      while (accepted_items < 460) send_line(1'b0);
      req_valid <= 1'b0;

      waited = 0;
      while (sb.awaited_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
         $display("serial_command_line_assembler_unit regression: pass");
      end else begin
         $display("serial_command_line_assembler_unit regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8_000_000;
      $display("serial_command_line_assembler_unit regression: fail");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
src/scla_pkg.sv
src/scla_line_ram.sv
src/serial_command_line_assembler_unit.sv
dv/tb.sv
